>>> sv/dph_pkg.sv
// ----------------------------------------------------------------------------
// Drude pair hard wall package
// Shared types, register codes and fixed-point helper functions.
// ----------------------------------------------------------------------------
package dph_pkg;

    localparam logic [30:0] WALL_LIMIT_RST = 31'd13107;
    localparam logic [30:0] THERMAL_RST    = 31'd65536;

    typedef enum logic [0:0] {
        REG_WALL_LIMIT = 1'b0,
        REG_THERMAL    = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_MUL  = 3'b001,
        OP_DIV  = 3'b010,
        OP_SQRT = 3'b100
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_16 = 2'd1,
        SH_30 = 2'd2
    } sh_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        return m;
    endfunction

    function automatic logic signed [63:0] sgn64(input logic [63:0] m, input logic neg);
        logic signed [63:0] s;
        s = neg ? -$signed(m) : $signed(m);
        return s;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [64:0] v);
        logic [31:0] s;
        if (v > 65'sd2147483647)
            s = 32'h7FFF_FFFF;
        else if (v < -65'sd2147483648)
            s = 32'h8000_0000;
        else
            s = v[31:0];
        return s;
    endfunction

    // Scaled product: magnitude shifted down, saturated to int64, sign applied.
    function automatic logic signed [63:0] mulsh_fix(input logic [127:0] p, input sh_t sh,
                                                     input logic neg);
        logic [127:0] q;
        logic [63:0]  m;
        case (sh)
            SH_16:   q = p >> 16;
            SH_30:   q = p >> 30;
            default: q = p;
        endcase
        if (q[127:63] != '0)
            m = 64'h7FFF_FFFF_FFFF_FFFF;
        else
            m = q[63:0];
        return sgn64(m, neg);
    endfunction

endpackage

>>> sv/dph_alu.sv
// ----------------------------------------------------------------------------
// Drude pair hard wall arithmetic unit
// Shared multi-cycle unit: 64x64 multiply in four 32x32 partial products,
// 64/64 restoring divide at one bit a cycle, 64-bit integer square root at
// two bits a cycle.
// ----------------------------------------------------------------------------
module dph_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  dph_pkg::alu_req_t req,
    input  logic [63:0]       a,
    input  logic [63:0]       b,
    output logic              done,
    output logic [127:0]      res
);
    import dph_pkg::*;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [5:0]    cnt_reg, cnt_next;
    alu_op_t       op_reg, op_next;
    logic [63:0]   a_reg, a_next;
    logic [63:0]   b_reg, b_next;
    logic [127:0]  acc_reg, acc_next;
    logic [63:0]   rem_reg, rem_next;

    logic [31:0]   a_half, b_half;
    logic [63:0]   pp;
    logic [127:0]  pp_sh;
    logic [64:0]   trial_d;
    logic [33:0]   trial_s, root_t;
    logic          last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        a_half    = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
        b_half    = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
        pp        = a_half * b_half;
        pp_sh     = '0;
        trial_d   = {rem_reg, a_reg[63]};
        trial_s   = {rem_reg[31:0], a_reg[63:62]};
        root_t    = {acc_reg[31:0], 2'b01};
        last      = 1'b0;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            op_next   = req.op;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    case (cnt_reg[1:0])
                        2'b00:   pp_sh = {64'b0, pp};
                        2'b11:   pp_sh = {pp, 64'b0};
                        default: pp_sh = {32'b0, pp, 32'b0};
                    endcase
                    acc_next = acc_reg + pp_sh;
                    last     = (cnt_reg == 6'd3);
                end
                OP_DIV:
                begin
                    if (trial_d >= {1'b0, b_reg})
                    begin
                        rem_next = 64'(trial_d - {1'b0, b_reg});
                        a_next   = {a_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial_d[63:0];
                        a_next   = {a_reg[62:0], 1'b0};
                    end
                    last = (cnt_reg == 6'd63);
                end
                default:
                begin
                    if (trial_s >= root_t)
                    begin
                        rem_next = 64'(trial_s - root_t);
                        acc_next = {96'b0, acc_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = 64'(trial_s);
                        acc_next = {96'b0, acc_reg[30:0], 1'b0};
                    end
                    a_next = {a_reg[61:0], 2'b00};
                    last   = (cnt_reg == 6'd31);
                end
            endcase
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 6'd1;
            end
        end
    end

    always_comb
    begin
        case (op_reg)
            OP_MUL:  res = acc_reg;
            OP_DIV:  res = {64'b0, a_reg};
            default: res = {96'b0, acc_reg[31:0]};
        endcase
    end

    assign done = done_reg;

endmodule

>>> sv/drude_pair_hard_wall_top.sv
// ----------------------------------------------------------------------------
// Drude pair hard wall
// Collects a core record and its Drude partner, and when the bond is longer
// than the wall limit but no more than twice it, reflects and rethermalizes
// the bond velocities and pulls both particles back inside the wall.
// ----------------------------------------------------------------------------
// Usage: the input channel takes a core transaction (is_drude low), which is
// stored and yields nothing, then a Drude transaction (is_drude high), which
// yields two output transactions: the core record, then the Drude record with
// last high. A Drude transaction without a stored core is dropped; a second
// core replaces the stored one. Configuration writes must be made while
// idle; the block itself does not enforce this. When no correction is
// needed, the first result follows four multiplies; when one is,
// it follows 30 multiplies, 10 divides and 2 square roots, all
// through the one shared arithmetic unit. in_stall stays high
// from the Drude transaction until the second result has been taken, so one
// pair is in flight at a time. While the receiver holds out_stall high, the
// current result stays on the outputs unchanged. Reset clears the stored
// core flag and loads the reset values of both registers.
// ----------------------------------------------------------------------------
module drude_pair_hard_wall_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic [23:0] particle_mass,
    input  logic        is_drude,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] new_pos_z,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic signed [31:0] new_vel_z,
    output logic        out_is_drude,
    output logic        corrected,
    output logic        too_far,
    output logic        last
);
    import dph_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    typedef enum logic [5:0] {
        S_SQ0, S_SQ1, S_SQ2, S_LIM, S_RT, S_DIR0, S_DIR1, S_DIR2,
        S_VC0, S_VC1, S_VC2, S_VD0, S_VD1, S_VD2, S_MC, S_MD, S_COM,
        S_TH, S_SC, S_DT, S_MS, S_VCN, S_MS2, S_VDN,
        S_DRC1, S_DRC2, S_DRC3, S_DRD1, S_DRD2, S_DRD3,
        S_OC0, S_OC1, S_OC2, S_OD0, S_OD1, S_OD2,
        S_OV0, S_OV1, S_OV2, S_DV0, S_DV1, S_DV2
    } step_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   core_held_reg, core_held_next;
    logic   sel_reg, sel_next;
    logic   corr_reg, corr_next;
    logic   far_reg, far_next;
    logic [30:0] wl_reg, tf_reg;

    logic signed [31:0] c_reg [6];
    logic signed [31:0] c_next [6];
    logic signed [31:0] d_reg [6];
    logic signed [31:0] d_next [6];
    logic [31:0] oc_reg [6];
    logic [31:0] oc_next [6];
    logic [31:0] od_reg [6];
    logic [31:0] od_next [6];
    logic signed [63:0] dir_reg [3];
    logic signed [63:0] dir_next [3];
    logic [23:0] mc_reg, mc_next, md_reg, md_next;
    logic [65:0] r2_reg, r2_next;
    logic [31:0] r_reg, r_next;
    logic signed [63:0] vcb_reg, vcb_next, vdb_reg, vdb_next;
    logic signed [63:0] t0_reg, t0_next, vcom_reg, vcom_next;
    logic [63:0] tmp_reg, tmp_next;
    logic [31:0] scale_reg, scale_next, dt_reg, dt_next;
    logic signed [63:0] vcn_reg, vcn_next, vdn_reg, vdn_next;
    logic signed [63:0] drc_reg, drc_next, drd_reg, drd_next;
    logic   neg_reg, neg_next;
    sh_t    sh_reg, sh_next;

    alu_req_t     alu_req;
    logic [63:0]  alu_a, alu_b;
    logic         alu_done;
    logic [127:0] alu_res;

    logic signed [32:0] bvec [3];
    logic [23:0]  mass_fix;
    logic [24:0]  mcom;
    logic [31:0]  dr_len;
    logic [63:0]  vrel_mag;
    logic signed [63:0] vcr, vdr, ev, dv;
    logic signed [63:0] mres, dres;
    logic [63:0]  dq;
    logic [1:0]   lane;
    logic [2:0]   vlane;
    logic [63:0]  bmag;
    logic         bneg;

    dph_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (alu_a),
        .b     (alu_b),
        .done  (alu_done),
        .res   (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= S_SQ0;
            core_held_reg <= 1'b0;
            sel_reg       <= 1'b0;
            wl_reg        <= WALL_LIMIT_RST;
            tf_reg        <= THERMAL_RST;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            core_held_reg <= core_held_next;
            sel_reg       <= sel_next;
            if (cfg_write)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_WALL_LIMIT: wl_reg <= cfg_data;
                    REG_THERMAL:    tf_reg <= cfg_data;
                    default:        wl_reg <= wl_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg     <= c_next;
        d_reg     <= d_next;
        oc_reg    <= oc_next;
        od_reg    <= od_next;
        dir_reg   <= dir_next;
        mc_reg    <= mc_next;
        md_reg    <= md_next;
        r2_reg    <= r2_next;
        r_reg     <= r_next;
        vcb_reg   <= vcb_next;
        vdb_reg   <= vdb_next;
        t0_reg    <= t0_next;
        vcom_reg  <= vcom_next;
        tmp_reg   <= tmp_next;
        scale_reg <= scale_next;
        dt_reg    <= dt_next;
        vcn_reg   <= vcn_next;
        vdn_reg   <= vdn_next;
        drc_reg   <= drc_next;
        drd_reg   <= drd_next;
        neg_reg   <= neg_next;
        sh_reg    <= sh_next;
        corr_reg  <= corr_next;
        far_reg   <= far_next;
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            bvec[k] = {d_reg[k][31], d_reg[k]} - {c_reg[k][31], c_reg[k]};
        end
        mass_fix = (particle_mass == 24'd0) ? 24'd1 : particle_mass;
        mcom     = {1'b0, mc_reg} + {1'b0, md_reg};
        dr_len   = (r_reg > {1'b0, wl_reg}) ? r_reg - {1'b0, wl_reg} : 32'd0;
        vrel_mag = mag64(vdb_reg - vcb_reg);
        vcr      = vcb_reg - vcom_reg;
        vdr      = vdb_reg - vcom_reg;
        ev       = vcn_reg + vcom_reg - vcb_reg;
        dv       = vdn_reg + vcom_reg - vdb_reg;
        mres     = mulsh_fix(alu_res, sh_reg, neg_reg);
        dq       = alu_res[63:0];
        dres     = sgn64(dq, neg_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        core_held_next = core_held_reg;
        sel_next       = sel_reg;
        corr_next      = corr_reg;
        far_next       = far_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        oc_next        = oc_reg;
        od_next        = od_reg;
        dir_next       = dir_reg;
        mc_next        = mc_reg;
        md_next        = md_reg;
        r2_next        = r2_reg;
        r_next         = r_reg;
        vcb_next       = vcb_reg;
        vdb_next       = vdb_reg;
        t0_next        = t0_reg;
        vcom_next      = vcom_reg;
        tmp_next       = tmp_reg;
        scale_next     = scale_reg;
        dt_next        = dt_reg;
        vcn_next       = vcn_reg;
        vdn_next       = vdn_reg;
        drc_next       = drc_reg;
        drd_next       = drd_reg;
        neg_next       = neg_reg;
        sh_next        = sh_reg;
        alu_req.start  = 1'b0;
        alu_req.op     = OP_MUL;
        alu_a          = '0;
        alu_b          = '0;
        lane           = 2'd0;
        vlane          = 3'd3;
        bmag           = '0;
        bneg           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!is_drude)
                    begin
                        c_next[0]      = pos_x;
                        c_next[1]      = pos_y;
                        c_next[2]      = pos_z;
                        c_next[3]      = vel_x;
                        c_next[4]      = vel_y;
                        c_next[5]      = vel_z;
                        mc_next        = mass_fix;
                        core_held_next = 1'b1;
                    end
                    else if (core_held_reg)
                    begin
                        d_next[0]      = pos_x;
                        d_next[1]      = pos_y;
                        d_next[2]      = pos_z;
                        d_next[3]      = vel_x;
                        d_next[4]      = vel_y;
                        d_next[5]      = vel_z;
                        md_next        = mass_fix;
                        core_held_next = 1'b0;
                        r2_next        = '0;
                        vcb_next       = '0;
                        vdb_next       = '0;
                        step_next      = S_SQ0;
                        state_next     = ST_ISSUE;
                    end
                end
            end

            ST_ISSUE:
            begin
                alu_req.start = 1'b1;
                neg_next      = 1'b0;
                sh_next       = SH_0;
                state_next    = ST_WAIT;
                case (step_reg)
                    S_SQ0, S_SQ1, S_SQ2:
                    begin
                        lane       = 2'(step_reg - S_SQ0);
                        bmag       = mag64({{31{bvec[lane][32]}}, bvec[lane]});
                        alu_a      = bmag;
                        alu_b      = bmag;
                    end
                    S_LIM:
                    begin
                        alu_a = {33'b0, wl_reg};
                        alu_b = {33'b0, wl_reg};
                    end
                    S_RT:
                    begin
                        alu_req.op = OP_SQRT;
                        alu_a      = r2_reg[63:0];
                    end
                    S_DIR0, S_DIR1, S_DIR2:
                    begin
                        lane       = 2'(step_reg - S_DIR0);
                        bmag       = mag64({{31{bvec[lane][32]}}, bvec[lane]});
                        bneg       = bvec[lane][32];
                        alu_req.op = OP_DIV;
                        alu_a      = bmag << 30;
                        alu_b      = {32'b0, r_reg};
                        neg_next   = bneg;
                    end
                    S_VC0, S_VC1, S_VC2:
                    begin
                        lane     = 2'(step_reg - S_VC0);
                        vlane    = 3'(lane) + 3'd3;
                        alu_a    = mag64(64'(c_reg[vlane]));
                        alu_b    = mag64(dir_reg[lane]);
                        neg_next = c_reg[vlane][31] ^ dir_reg[lane][63];
                        sh_next  = SH_30;
                    end
                    S_VD0, S_VD1, S_VD2:
                    begin
                        lane     = 2'(step_reg - S_VD0);
                        vlane    = 3'(lane) + 3'd3;
                        alu_a    = mag64(64'(d_reg[vlane]));
                        alu_b    = mag64(dir_reg[lane]);
                        neg_next = d_reg[vlane][31] ^ dir_reg[lane][63];
                        sh_next  = SH_30;
                    end
                    S_MC:
                    begin
                        alu_a    = {40'b0, mc_reg};
                        alu_b    = mag64(vcb_reg);
                        neg_next = vcb_reg[63];
                    end
                    S_MD:
                    begin
                        alu_a    = {40'b0, md_reg};
                        alu_b    = mag64(vdb_reg);
                        neg_next = vdb_reg[63];
                    end
                    S_COM:
                    begin
                        alu_req.op = OP_DIV;
                        alu_a      = mag64(t0_reg);
                        alu_b      = {39'b0, mcom};
                        neg_next   = t0_reg[63];
                    end
                    S_TH:
                    begin
                        alu_req.op = OP_DIV;
                        alu_a      = {9'b0, tf_reg, 24'b0};
                        alu_b      = {40'b0, md_reg};
                    end
                    S_SC:
                    begin
                        alu_req.op = OP_SQRT;
                        alu_a      = tmp_reg;
                    end
                    S_DT:
                    begin
                        alu_req.op = OP_DIV;
                        alu_a      = {16'b0, dr_len, 16'b0};
                        alu_b      = vrel_mag;
                    end
                    S_MS:
                    begin
                        alu_a = {40'b0, md_reg};
                        alu_b = {32'b0, scale_reg};
                    end
                    S_VCN:
                    begin
                        alu_req.op = OP_DIV;
                        alu_a      = tmp_reg;
                        alu_b      = {39'b0, mcom};
                        neg_next   = (vcr > 64'sd0);
                    end
                    S_MS2:
                    begin
                        alu_a = {40'b0, mc_reg};
                        alu_b = {32'b0, scale_reg};
                    end
                    S_VDN:
                    begin
                        alu_req.op = OP_DIV;
                        alu_a      = tmp_reg;
                        alu_b      = {39'b0, mcom};
                        neg_next   = !vdr[63];
                    end
                    S_DRC1:
                    begin
                        alu_a = {32'b0, dr_len};
                        alu_b = {40'b0, md_reg};
                    end
                    S_DRD1:
                    begin
                        alu_a = {32'b0, dr_len};
                        alu_b = {40'b0, mc_reg};
                    end
                    S_DRC2, S_DRD2:
                    begin
                        alu_req.op = OP_DIV;
                        alu_a      = tmp_reg;
                        alu_b      = {39'b0, mcom};
                        neg_next   = (step_reg == S_DRD2);
                    end
                    S_DRC3:
                    begin
                        alu_a    = {32'b0, dt_reg};
                        alu_b    = mag64(vcn_reg);
                        neg_next = vcn_reg[63];
                        sh_next  = SH_16;
                    end
                    S_DRD3:
                    begin
                        alu_a    = {32'b0, dt_reg};
                        alu_b    = mag64(vdn_reg);
                        neg_next = vdn_reg[63];
                        sh_next  = SH_16;
                    end
                    S_OC0, S_OC1, S_OC2:
                    begin
                        lane     = 2'(step_reg - S_OC0);
                        alu_a    = mag64(dir_reg[lane]);
                        alu_b    = mag64(drc_reg);
                        neg_next = dir_reg[lane][63] ^ drc_reg[63];
                        sh_next  = SH_30;
                    end
                    S_OD0, S_OD1, S_OD2:
                    begin
                        lane     = 2'(step_reg - S_OD0);
                        alu_a    = mag64(dir_reg[lane]);
                        alu_b    = mag64(drd_reg);
                        neg_next = dir_reg[lane][63] ^ drd_reg[63];
                        sh_next  = SH_30;
                    end
                    S_OV0, S_OV1, S_OV2:
                    begin
                        lane     = 2'(step_reg - S_OV0);
                        alu_a    = mag64(dir_reg[lane]);
                        alu_b    = mag64(ev);
                        neg_next = dir_reg[lane][63] ^ ev[63];
                        sh_next  = SH_30;
                    end
                    S_DV0, S_DV1, S_DV2:
                    begin
                        lane     = 2'(step_reg - S_DV0);
                        alu_a    = mag64(dir_reg[lane]);
                        alu_b    = mag64(dv);
                        neg_next = dir_reg[lane][63] ^ dv[63];
                        sh_next  = SH_30;
                    end
                    default:
                    begin
                        alu_a = '0;
                    end
                endcase
            end

            ST_WAIT:
            begin
                if (alu_done)
                begin
                    step_next  = step_t'(step_reg + 6'd1);
                    state_next = ST_ISSUE;
                    case (step_reg)
                        S_SQ0, S_SQ1, S_SQ2:
                        begin
                            r2_next = r2_reg + alu_res[65:0];
                        end
                        S_LIM:
                        begin
                            if (r2_reg > {2'b0, alu_res[61:0], 2'b00} ||
                                r2_reg <= {4'b0, alu_res[61:0]})
                            begin
                                for (int k = 0; k < 6; k++)
                                begin
                                    oc_next[k] = c_reg[k];
                                    od_next[k] = d_reg[k];
                                end
                                far_next   = (r2_reg > {2'b0, alu_res[61:0], 2'b00});
                                corr_next  = 1'b0;
                                sel_next   = 1'b0;
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                far_next  = 1'b0;
                                corr_next = 1'b1;
                            end
                        end
                        S_RT:
                        begin
                            r_next = alu_res[31:0];
                        end
                        S_DIR0, S_DIR1, S_DIR2:
                        begin
                            lane           = 2'(step_reg - S_DIR0);
                            dir_next[lane] = dres;
                        end
                        S_VC0, S_VC1, S_VC2:
                        begin
                            vcb_next = vcb_reg + mres;
                        end
                        S_VD0, S_VD1, S_VD2:
                        begin
                            vdb_next = vdb_reg + mres;
                        end
                        S_MC:
                        begin
                            t0_next = mres;
                        end
                        S_MD:
                        begin
                            t0_next = t0_reg + mres;
                        end
                        S_COM:
                        begin
                            vcom_next = dres;
                        end
                        S_TH:
                        begin
                            tmp_next = dq;
                        end
                        S_SC:
                        begin
                            scale_next = alu_res[31:0];
                        end
                        S_DT:
                        begin
                            dt_next = (dq[63:32] != '0) ? 32'hFFFF_FFFF : dq[31:0];
                        end
                        S_MS, S_MS2, S_DRC1, S_DRD1:
                        begin
                            tmp_next = alu_res[63:0];
                        end
                        S_VCN:
                        begin
                            vcn_next = dres;
                        end
                        S_VDN:
                        begin
                            vdn_next = dres;
                        end
                        S_DRC2:
                        begin
                            drc_next = dres;
                        end
                        S_DRD2:
                        begin
                            drd_next = dres;
                        end
                        S_DRC3:
                        begin
                            drc_next = drc_reg + mres;
                        end
                        S_DRD3:
                        begin
                            drd_next = drd_reg + mres;
                        end
                        S_OC0, S_OC1, S_OC2:
                        begin
                            lane          = 2'(step_reg - S_OC0);
                            oc_next[lane] = sat32(65'(c_reg[lane]) + 65'(mres));
                        end
                        S_OD0, S_OD1, S_OD2:
                        begin
                            lane          = 2'(step_reg - S_OD0);
                            od_next[lane] = sat32(65'(d_reg[lane]) + 65'(mres));
                        end
                        S_OV0, S_OV1, S_OV2:
                        begin
                            lane           = 2'(step_reg - S_OV0);
                            vlane          = 3'(lane) + 3'd3;
                            oc_next[vlane] = sat32(65'(c_reg[vlane]) + 65'(mres));
                        end
                        S_DV0, S_DV1, S_DV2:
                        begin
                            lane           = 2'(step_reg - S_DV0);
                            vlane          = 3'(lane) + 3'd3;
                            od_next[vlane] = sat32(65'(d_reg[vlane]) + 65'(mres));
                            if (step_reg == S_DV2)
                            begin
                                sel_next   = 1'b0;
                                step_next  = S_SQ0;
                                state_next = ST_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_OUT:
            begin
                if (!out_stall)
                begin
                    if (!sel_reg)
                    begin
                        sel_next = 1'b1;
                    end
                    else
                    begin
                        sel_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = (state_reg == ST_OUT);
    assign new_pos_x    = sel_reg ? od_reg[0] : oc_reg[0];
    assign new_pos_y    = sel_reg ? od_reg[1] : oc_reg[1];
    assign new_pos_z    = sel_reg ? od_reg[2] : oc_reg[2];
    assign new_vel_x    = sel_reg ? od_reg[3] : oc_reg[3];
    assign new_vel_y    = sel_reg ? od_reg[4] : oc_reg[4];
    assign new_vel_z    = sel_reg ? od_reg[5] : oc_reg[5];
    assign out_is_drude = sel_reg;
    assign corrected    = corr_reg;
    assign too_far      = far_reg;
    assign last         = sel_reg;

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Drude pair hard wall testbench
// Drives core and Drude transactions with random gaps and stalls, predicts
// the pair records, and compares every result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class pair_scoreboard;
    typedef struct {
        logic [31:0] v[6];
        logic        drude;
        logic        corr;
        logic        far;
        logic        lst;
    } rec_t;

    rec_t        pending[$];
    logic [30:0] limit;
    logic [30:0] factor;
    logic [31:0] core_vec[6];
    logic [23:0] core_mass;
    bit          have_core;
    int          errors;

    function void reset_state();
        limit = dph_pkg::WALL_LIMIT_RST;
        factor = dph_pkg::THERMAL_RST;
        have_core = 0;
        pending.delete();
        errors = 0;
    endfunction

    function void set_reg(dph_pkg::reg_idx_t idx, logic [30:0] val);
        if (idx == dph_pkg::REG_WALL_LIMIT)
            limit = val;
        else
            factor = val;
    endfunction

    static function logic [63:0] root(logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    static function longint scaled(longint a, longint b, int s);
        logic [127:0] p;
        logic [63:0]  ma, mb;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = ({64'd0, ma} * {64'd0, mb}) >> s;
        if (p > 128'h7FFF_FFFF_FFFF_FFFF)
            p = 128'h7FFF_FFFF_FFFF_FFFF;
        return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    static function longint tdiv(longint n, logic [63:0] d);
        logic [63:0] q;
        q = (n < 0 ? 64'(-n) : 64'(n)) / d;
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    static function logic [31:0] clip(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function void push(longint c[6], longint d[6], bit corr, bit far);
        rec_t a, z;
        for (int k = 0; k < 6; k++)
        begin
            a.v[k] = clip(c[k]);
            z.v[k] = clip(d[k]);
        end
        a.drude = 0; a.corr = corr; a.far = far; a.lst = 0;
        z.drude = 1; z.corr = corr; z.far = far; z.lst = 1;
        pending.push_back(a);
        pending.push_back(z);
    endfunction

    function void note_input(logic [31:0] f[6], logic [23:0] m, logic drude);
        longint c[6], d[6], b[3], dir[3], oc[6], od[6];
        longint vcb, vdb, vcom, vcr, vdr, vcn, vdn, drc, drd, dlr;
        logic [63:0] mc, md, mcom, sq, r, sc, dt, vrel, lim2;
        logic [65:0] r2;
        if (!drude)
        begin
            core_vec = f;
            core_mass = m;
            have_core = 1;
            return;
        end
        if (!have_core)
            return;
        have_core = 0;
        for (int k = 0; k < 6; k++)
        begin
            c[k] = longint'($signed(core_vec[k]));
            d[k] = longint'($signed(f[k]));
        end
        mc = core_mass != 0 ? core_mass : 1;
        md = m != 0 ? m : 1;
        mcom = mc + md;
        r2 = 0;
        for (int k = 0; k < 3; k++)
        begin
            b[k] = d[k] - c[k];
            sq = (b[k] < 0 ? -b[k] : b[k]);
            r2 += sq * sq;
        end
        lim2 = 64'(limit) * limit;
        if (r2 > {lim2, 2'b00} || r2 > 66'hFFFF_FFFF_FFFF_FFFF)
        begin
            push(c, d, 0, 1);
            return;
        end
        if (r2 <= lim2)
        begin
            push(c, d, 0, 0);
            return;
        end
        r = root(r2[63:0]);
        vcb = 0;
        vdb = 0;
        for (int k = 0; k < 3; k++)
        begin
            dir[k] = tdiv(b[k] * 1073741824, r);
            vcb += scaled(c[3 + k], dir[k], 30);
            vdb += scaled(d[3 + k], dir[k], 30);
        end
        vcom = tdiv(longint'(mc) * vcb + longint'(md) * vdb, mcom);
        sc = root((64'(factor) << 24) / md);
        vcr = vcb - vcom;
        vdr = vdb - vcom;
        dlr = r > limit ? longint'(r - limit) : 0;
        vrel = (vdr - vcr) < 0 ? -(vdr - vcr) : (vdr - vcr);
        if (vrel == 0)
            dt = 64'hFFFF_FFFF;
        else
        begin
            dt = (64'(dlr) << 16) / vrel;
            if (dt > 64'hFFFF_FFFF)
                dt = 64'hFFFF_FFFF;
        end
        vcn = longint'((md * sc) / mcom);
        if (vcr > 0)
            vcn = -vcn;
        vdn = longint'((mc * sc) / mcom);
        if (vdr >= 0)
            vdn = -vdn;
        drc = tdiv(dlr * longint'(md), mcom) + scaled(longint'(dt), vcn, 16);
        drd = -tdiv(dlr * longint'(mc), mcom) + scaled(longint'(dt), vdn, 16);
        for (int k = 0; k < 3; k++)
        begin
            oc[k] = c[k] + scaled(dir[k], drc, 30);
            od[k] = d[k] + scaled(dir[k], drd, 30);
            oc[3 + k] = c[3 + k] + scaled(dir[k], vcn + vcom - vcb, 30);
            od[3 + k] = d[3 + k] + scaled(dir[k], vdn + vcom - vdb, 30);
        end
        push(oc, od, 1, 0);
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a)
        begin
            $error("%s expected %h actual %h", name, e, a);
            errors++;
        end
    endfunction

    function void check_result(logic [31:0] v[6], logic dr, logic co, logic tf, logic ls);
        rec_t e;
        string names[6] = '{"new_pos_x", "new_pos_y", "new_pos_z",
                            "new_vel_x", "new_vel_y", "new_vel_z"};
        if (pending.size() == 0)
        begin
            $error("unexpected result transaction");
            errors++;
            return;
        end
        e = pending.pop_front();
        for (int k = 0; k < 6; k++)
            cmp(names[k], e.v[k], v[k]);
        cmp("out_is_drude", e.drude, dr);
        cmp("corrected", e.corr, co);
        cmp("too_far", e.far, tf);
        cmp("last", e.lst, ls);
    endfunction
endclass

module tb;
    import dph_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_write = 0;
    logic [0:0] cfg_index = '0;
    logic [30:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
    logic signed [31:0] vel_x = 0, vel_y = 0, vel_z = 0;
    logic [23:0] particle_mass = 1;
    logic is_drude = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [31:0] new_pos_x, new_pos_y, new_pos_z;
    logic signed [31:0] new_vel_x, new_vel_y, new_vel_z;
    logic out_is_drude, corrected, too_far, last;

    pair_scoreboard board = new();
    bit busy_idle = 1;
    int hold_off = 0;

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    drude_pair_hard_wall_top DUT (.*);

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    task automatic send(logic [31:0] f[6], logic [23:0] m, logic drude);
        while (busy_idle && $urandom_range(0, 99) < 26)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        pos_x <= f[0]; pos_y <= f[1]; pos_z <= f[2];
        vel_x <= f[3]; vel_y <= f[4]; vel_z <= f[5];
        particle_mass <= m;
        is_drude <= drude;
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(f, m, drude);
    endtask

    task automatic send_pair(logic [30:0] lim, int mode);
        logic [31:0] c[6], d[6];
        int span;
        for (int k = 0; k < 6; k++)
        begin
            c[k] = rnd_val();
            d[k] = (k < 3) ? c[k] : rnd_val();
        end
        span = (mode == 0) ? int'(lim) / 2 + 1 : (mode == 1) ? int'(lim) * 3 / 2 + 2 : int'(lim) * 3;
        if (span < 1)
            span = 1;
        for (int k = 0; k < 3; k++)
            d[k] = c[k] + 32'($signed($urandom_range(0, 2 * span)) - span);
        send(c, 24'($urandom_range(1, 2000)), 0);
        send(d, $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(1, 2000)), 1);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [30:0] val);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 0;
        board.set_reg(idx, val);
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result('{new_pos_x, new_pos_y, new_pos_z,
                                 new_vel_x, new_vel_y, new_vel_z},
                               out_is_drude, corrected, too_far, last);
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1;
        end
        else
            out_stall <= busy_idle && ($urandom_range(0, 99) < 26);
    end

    initial
    begin
        logic [31:0] z[6], mx[6], mn[6];
        logic [30:0] lims[4] = '{31'd13107, 31'd1, 31'd65536, 31'h7FFF_FFFF};
        logic [30:0] facs[4] = '{31'd65536, 31'd0, 31'h7FFF_FFFF, 31'd300};
        board.reset_state();
        z = '{0, 0, 0, 0, 0, 0};
        mx = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        mn = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send(z, 24'd5, 1);
        send(z, 24'd0, 0);
        send(z, 24'd0, 1);
        send(mn, 24'hFFFFFF, 0);
        send(mx, 24'hFFFFFF, 1);
        send(z, 24'd100, 0);
        send(mx, 24'd1, 0);
        send(mn, 24'd1, 1);
        send(z, 24'd256, 0);
        send('{32'h0000_8000, 0, 0, 0, 0, 0}, 24'd256, 1);
        send(z, 24'd256, 0);
        send('{32'h0000_5000, 32'h1000, 0, 32'h100, 0, 0}, 24'd64, 1);
        send('{0, 0, 0, 32'h10000, 0, 0}, 24'd256, 0);
        send('{32'h4000, 0, 0, 32'hFFFF0000, 0, 0}, 24'd256, 1);
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_WALL_LIMIT, lims[ph]);
            write_reg(REG_THERMAL, facs[ph]);
            busy_idle = (ph != 1);
            for (int i = 0; i < 220; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    logic [31:0] f[6];
                    foreach (f[k]) f[k] = rnd_val();
                    send(f, 24'($urandom), 1'($urandom));
                end
                else
                    send_pair(ph == 3 ? 31'($urandom_range(1, 200000)) : lims[ph],
                              $urandom_range(0, 2));
                if (i == 100)
                    hold_off = 400;
                if (i == 150)
                begin
                    in_valid <= 0;
                    while (board.pending.size() != 0)
                        @(posedge clk);
                end
            end
            busy_idle = 1;
            drain();
        end
        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("status: fail");
        $finish;
    end
endmodule

>>> drude_pair_hard_wall_top.f
sv/dph_pkg.sv
sv/dph_alu.sv
sv/drude_pair_hard_wall_top.sv
test/tb.sv
